// ===== rtl/core/dedup_ordered_key_table_assert.svh =====
// Assertion macros used by the top RTL file of the key table.
`ifndef DEDUP_ORDERED_KEY_TABLE_ASSERT_SVH
`define DEDUP_ORDERED_KEY_TABLE_ASSERT_SVH

`ifndef SYNTH
`define DOK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DOK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define DOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/dok_pkg.sv =====
package dok_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam int OPCODE_W = 2;
	localparam int KEY_W = 32;
	localparam int POS_W = 6;
	localparam int STATUS_W = 3;
	localparam int HELD_W = 7;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;

	localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] ST_SUCCESS = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 3'd4;

	typedef struct packed {
		logic latch;
		logic scan_start;
		logic read_pos;
		logic write_key;
		logic res_en;
		logic [STATUS_W-1:0] res_status;
		logic res_found;
		logic res_use_mem;
	} dok_cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic key_zero;
		logic count_zero;
		logic pos_ok;
		logic full;
		logic hit;
		logic scan_done;
	} dok_sts_t;

endpackage

// ===== rtl/core/dedup_ordered_key_table.sv =====
// An append or query over the held keys scans the table, reading one stored key per cycle,
// and then presents its result; against an empty table the scan is skipped. A read passes
// through a read-wait state, and a refused or invalid request goes straight to the output.
// Input is accepted again the cycle after the result transaction, so one item must be through
// before the next is taken.
// The asynchronous reset empties the table; the key store itself is not cleared.
`include "dedup_ordered_key_table_assert.svh"

module dedup_ordered_key_table #(
	parameter int CAPACITY = dok_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = dok_pkg::KEY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key [31:0], position [37:32], zero fill above.
	input  logic [dok_pkg::S_TDATA_W-1:0]   s_tdata,
	// opcode [1:0].
	input  logic [dok_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status [2:0], found [3], entry_key [35:4], held_count [42:36], zero fill above.
	output logic [dok_pkg::M_TDATA_W-1:0]   m_tdata
);

	dok_pkg::dok_cmd_t cmd;
	dok_pkg::dok_sts_t sts;

	logic [dok_pkg::STATUS_W-1:0] status;
	logic                         found;
	logic [dok_pkg::KEY_W-1:0]    entry_key;
	logic [dok_pkg::HELD_W-1:0]   held_count;

	dok_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dok_dpath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (s_tuser[dok_pkg::OPCODE_W-1:0]),
		.key        (s_tdata[dok_pkg::KEY_W-1:0]),
		.position   (s_tdata[dok_pkg::KEY_W +: dok_pkg::POS_W]),
		.cmd        (cmd),
		.sts        (sts),
		.status     (status),
		.found      (found),
		.entry_key  (entry_key),
		.held_count (held_count)
	);

	assign m_tdata = {5'b0, held_count, entry_key, found, status};

	`DOK_ASSERT_SAME(a_one_side, clk, arst_n, s_tready, !m_tvalid, "ready while a result is pending")
	`DOK_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "accepted a second transaction")
	`DOK_ASSERT_SAME(a_key_on_error, clk, arst_n, m_tvalid && status != dok_pkg::ST_SUCCESS, entry_key == '0, "entry key set on error")

endmodule

// ===== rtl/core/dok_ctrl.sv =====
module dok_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  dok_pkg::dok_sts_t sts,
	output dok_pkg::dok_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_FINISH = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.op == dok_pkg::OP_READ) begin
					if (sts.pos_ok) begin
						cmd.read_pos = 1'b1;
						state_nx = S_RDWAIT;
					end else begin
						cmd.res_en = 1'b1;
						cmd.res_status = dok_pkg::ST_NO_ENTRY;
						state_nx = S_OUT;
					end
				end else if ((sts.op == dok_pkg::OP_APPEND || sts.op == dok_pkg::OP_QUERY)
						&& !sts.key_zero) begin
					if (sts.count_zero) begin
						state_nx = S_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						state_nx = S_SCAN;
					end
				end else begin
					cmd.res_en = 1'b1;
					cmd.res_status = dok_pkg::ST_INVALID;
					state_nx = S_OUT;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_nx = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.res_en = 1'b1;
				if (sts.op == dok_pkg::OP_QUERY) begin
					cmd.res_status = dok_pkg::ST_SUCCESS;
					cmd.res_found = sts.hit;
				end else if (sts.hit) begin
					cmd.res_status = dok_pkg::ST_DUPLICATE;
				end else if (sts.full) begin
					cmd.res_status = dok_pkg::ST_FULL;
				end else begin
					cmd.res_status = dok_pkg::ST_SUCCESS;
					cmd.write_key = 1'b1;
				end
				state_nx = S_OUT;
			end
			S_RDWAIT: begin
				cmd.res_en = 1'b1;
				cmd.res_status = dok_pkg::ST_SUCCESS;
				cmd.res_use_mem = 1'b1;
				state_nx = S_OUT;
			end
			S_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/dok_dpath.sv =====
module dok_dpath #(
	parameter int CAPACITY = dok_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = dok_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [dok_pkg::OPCODE_W-1:0]   opcode,
	input  logic [dok_pkg::KEY_W-1:0]      key,
	input  logic [dok_pkg::POS_W-1:0]      position,
	input  dok_pkg::dok_cmd_t              cmd,
	output dok_pkg::dok_sts_t              sts,
	output logic [dok_pkg::STATUS_W-1:0]   status,
	output logic                           found,
	output logic [dok_pkg::KEY_W-1:0]      entry_key,
	output logic [dok_pkg::HELD_W-1:0]     held_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + dok_pkg::POS_W;

	logic [KEY_BITS-1:0] mem [CAPACITY];

	logic [dok_pkg::OPCODE_W-1:0] op_q;
	logic [KEY_BITS-1:0]          key_q;
	logic [dok_pkg::POS_W-1:0]    pos_q;
	logic [CW-1:0]                count_q;
	logic [IW-1:0]                idx_q;
	logic                         scanning_q;
	logic                         cmp_vld_s1;
	logic                         cmp_last_s1;
	logic                         hit_q;
	logic [KEY_BITS-1:0]          rd_data_q;
	logic [dok_pkg::STATUS_W-1:0] status_q;
	logic                         found_q;
	logic [dok_pkg::KEY_W-1:0]    ekey_q;

	logic          last_issue;
	logic          rd_en;
	logic [IW-1:0] rd_addr;

	assign last_issue = (CW'(idx_q) + CW'(1)) == count_q;
	assign rd_en = scanning_q || cmd.read_pos;
	assign rd_addr = scanning_q ? idx_q : IW'(pos_q);

	always_ff @(posedge clk) begin
		if (cmd.write_key) begin
			mem[IW'(count_q)] <= key_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= opcode;
			key_q <= KEY_BITS'(key);
			pos_q <= position;
		end
		if (cmd.scan_start) begin
			idx_q <= '0;
		end else if (scanning_q) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.res_en) begin
			status_q <= cmd.res_status;
			found_q <= cmd.res_found;
			ekey_q <= cmd.res_use_mem ? dok_pkg::KEY_W'(rd_data_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scanning_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			cmp_last_s1 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.write_key) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_start) begin
				scanning_q <= 1'b1;
			end else if (scanning_q && last_issue) begin
				scanning_q <= 1'b0;
			end
			cmp_vld_s1 <= scanning_q;
			cmp_last_s1 <= scanning_q && last_issue;
			if (cmd.latch) begin
				hit_q <= 1'b0;
			end else if (cmp_vld_s1 && rd_data_q == key_q) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.op = op_q;
		sts.key_zero = key_q == '0;
		sts.count_zero = count_q == '0;
		sts.pos_ok = ({{CW{1'b0}}, pos_q} < {{dok_pkg::POS_W{1'b0}}, count_q})
			&& ({{CW{1'b0}}, pos_q} < PW'(CAPACITY));
		sts.full = count_q == CW'(CAPACITY);
		sts.hit = hit_q;
		sts.scan_done = cmp_vld_s1 && cmp_last_s1;
	end

	assign status = status_q;
	assign found = found_q;
	assign entry_key = ekey_q;
	assign held_count = dok_pkg::HELD_W'(count_q);

endmodule

// ===== tb/dedup_ordered_key_table_tb.sv =====
`timescale 1ns / 100ps

module dedup_ordered_key_table_tb;
	import dok_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int TABLE_DEPTH = CAPACITY_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
	localparam int FOUND_BIT = STATUS_W;
	localparam int ENTRY_LSB = STATUS_W + 1;
	localparam int HELD_LSB = ENTRY_LSB + KEY_W;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic found;
		logic [KEY_W-1:0] entry_key;
		logic [HELD_W-1:0] held_count;
	} table_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	logic [KEY_W-1:0] model_keys [TABLE_DEPTH];
	int model_count = 0;
	table_outcome_t awaited_outcomes [$];
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int outcomes_checked = 0;
	int status_seen [8];

	dedup_ordered_key_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic bit model_holds(logic [KEY_W-1:0] key);
		for (int i = 0; i < model_count; i++) begin
			if (model_keys[i] == key) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic table_outcome_t apply_table_op(logic [OPCODE_W-1:0] op,
			logic [KEY_W-1:0] key, logic [POS_W-1:0] pos);
		table_outcome_t res;
		res = '0;
		res.status = ST_SUCCESS;
		case (op)
			OP_APPEND: begin
				if (key == '0) begin
					res.status = ST_INVALID;
				end else if (model_holds(key)) begin
					res.status = ST_DUPLICATE;
				end else if (model_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					model_keys[model_count] = key;
					model_count++;
				end
			end
			OP_READ: begin
				if (int'(pos) < model_count) begin
					res.entry_key = model_keys[pos];
				end else begin
					res.status = ST_NO_ENTRY;
				end
			end
			OP_QUERY: begin
				if (key == '0) begin
					res.status = ST_INVALID;
				end else begin
					res.found = model_holds(key);
				end
			end
			default: begin
				res.status = ST_INVALID;
			end
		endcase
		res.held_count = HELD_W'(model_count);
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
		error_count++;
	endtask

	task automatic send_item(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
			logic [POS_W-1:0] pos);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W - POS_W - KEY_W){1'b0}}, pos, key};
		do @(posedge clk); while (!s_tready);
		awaited_outcomes.push_back(apply_table_op(op, key, pos));
		items_sent++;
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_held_key();
		return model_keys[$urandom_range(model_count - 1)];
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] key;
		do key = $urandom; while (key == '0 || model_holds(key));
		return key;
	endfunction

	task automatic send_random_item();
		int pick;
		int sub;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] pos;
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		key = $urandom;
		pos = POS_W'($urandom_range(TABLE_DEPTH - 1));
		if (pick < 40) begin
			if (sub < 45) begin
				key = fresh_key();
			end else if (sub < 90 && model_count > 0) begin
				key = pick_held_key();
			end else if (sub >= 90) begin
				key = '0;
			end
			send_item(OP_APPEND, key, pos);
		end else if (pick < 65) begin
			if (sub < 70 && model_count > 0) begin
				pos = POS_W'($urandom_range(model_count - 1));
			end
			send_item(OP_READ, key, pos);
		end else if (pick < 92) begin
			if (sub < 50 && model_count > 0) begin
				key = pick_held_key();
			end else if (sub >= 90) begin
				key = '0;
			end
			send_item(OP_QUERY, key, pos);
		end else begin
			send_item(OP_UNUSED, key, pos);
		end
	endtask

	task automatic test_empty_table();
		send_item(OP_READ, 32'h0000_0000, 6'd0);
		send_item(OP_READ, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_QUERY, 32'h0000_0005, 6'd0);
		send_item(OP_QUERY, 32'h0000_0000, 6'd63);
		send_item(OP_APPEND, 32'h0000_0000, 6'd0);
		send_item(OP_UNUSED, 32'h1234_5678, 6'd17);
	endtask

	task automatic test_append_and_readback();
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_APPEND, 32'h0000_0001, 6'd0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_APPEND, 32'h8000_0000, 6'd42);
		send_item(OP_APPEND, 32'hA5A5_5A5A, 6'd21);
		send_item(OP_READ, 32'h0000_0000, 6'd0);
		send_item(OP_READ, 32'hFFFF_FFFF, 6'd1);
		send_item(OP_READ, 32'h0000_0000, 6'd3);
		send_item(OP_READ, 32'h0000_0000, 6'd4);
		send_item(OP_READ, 32'h0000_0000, 6'd63);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_QUERY, 32'h0000_0001, 6'd0);
		send_item(OP_QUERY, 32'h7FFF_FFFF, 6'd0);
		send_item(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_UNUSED, 32'h0000_0000, 6'd0);
	endtask

	task automatic test_random_traffic(int count, int send_idle, int recv_stall);
		sender_idle_pct = send_idle;
		receiver_stall_pct = recv_stall;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				wait_until_drained();
			end
			send_random_item();
		end
	endtask

	task automatic test_full_table();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		while (model_count < TABLE_DEPTH) begin
			send_item(OP_APPEND, fresh_key(), POS_W'($urandom));
		end
		send_item(OP_APPEND, fresh_key(), 6'd0);
		send_item(OP_APPEND, pick_held_key(), 6'd0);
		send_item(OP_APPEND, model_keys[TABLE_DEPTH - 1], 6'd0);
		send_item(OP_APPEND, 32'h0000_0000, 6'd0);
		send_item(OP_READ, 32'h0000_0000, 6'd63);
		send_item(OP_QUERY, model_keys[TABLE_DEPTH - 1], 6'd0);
		send_item(OP_QUERY, fresh_key(), 6'd0);
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		table_outcome_t got;
		table_outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[STATUS_W-1:0];
			got.found = m_tdata[FOUND_BIT];
			got.entry_key = m_tdata[ENTRY_LSB +: KEY_W];
			got.held_count = m_tdata[HELD_LSB +: HELD_W];
			if (awaited_outcomes.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, 64'(m_tdata));
			end else begin
				want = awaited_outcomes.pop_front();
				outcomes_checked++;
				status_seen[got.status]++;
				if (got.status !== want.status) begin
					report_mismatch("status", 64'(want.status), 64'(got.status));
				end
				if (got.found !== want.found) begin
					report_mismatch("found", 64'(want.found), 64'(got.found));
				end
				if (got.entry_key !== want.entry_key) begin
					report_mismatch("entry_key", 64'(want.entry_key), 64'(got.entry_key));
				end
				if (got.held_count !== want.held_count) begin
					report_mismatch("held_count", 64'(want.held_count), 64'(got.held_count));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("[dedup_ordered_key_table] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_append_and_readback();
		test_random_traffic(200, 16, 78);
		test_random_traffic(200, 78, 16);
		test_full_table();
		test_random_traffic(150, 0, 0);
		wait_until_drained();
		$display("Ran %0d transactions with %0d results checked over %0d cycles.",
			items_sent, outcomes_checked, cycle_count);
		$display("Status mix: %0d success, %0d duplicate, %0d full, %0d invalid, %0d no entry.",
			status_seen[ST_SUCCESS], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
			status_seen[ST_INVALID], status_seen[ST_NO_ENTRY]);
		if (error_count == 0) begin
			$display("[dedup_ordered_key_table] OK");
		end else begin
			$display("[dedup_ordered_key_table] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dok_pkg.sv
rtl/core/dok_ctrl.sv
rtl/core/dok_dpath.sv
rtl/core/dedup_ordered_key_table.sv
tb/dedup_ordered_key_table_tb.sv
